// ----- sv/lscl_pkg.sv -----
// Package for the LRU slot cache lookup block.
// Holds the default sizes, the controller state type and the flag groups
// that travel along the slot chain. No dependencies.
package lscl_pkg;

   localparam int DEF_SLOTS      = 8;
   localparam int DEF_FRAME_BITS = 16;
   localparam int DEF_STAMP_BITS = 32;

   localparam int REQ_FRAME_W = 16;
   localparam int RSP_SLOT_W  = 3;
   localparam int RSP_FRAME_W = 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic active;
      logic hit;
      logic best_set;
      logic best_valid;
   } scan_flags_type;

   typedef struct packed {
      logic en;
      logic fill;
   } wr_flags_type;

endpackage

// ----- sv/lscl_slot.sv -----
// One slot of the cache directory: valid bit, frame and stamp.
// Updates the search record handed in by its left neighbor and registers it
// for its right neighbor. Depends on lscl_pkg.
module lscl_slot #(
   parameter int SLOTS      = lscl_pkg::DEF_SLOTS,
   parameter int FRAME_BITS = lscl_pkg::DEF_FRAME_BITS,
   parameter int STAMP_BITS = lscl_pkg::DEF_STAMP_BITS,
   parameter int IDX_BITS   = 3,
   parameter int CELL_IDX   = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lscl_pkg::scan_flags_type in_flags,
   input  logic [FRAME_BITS-1:0]  in_frame,
   input  logic [IDX_BITS-1:0]    in_hit_idx,
   input  logic [IDX_BITS-1:0]    in_best_idx,
   input  logic [STAMP_BITS-1:0]  in_best_stamp,
   input  logic [FRAME_BITS-1:0]  in_best_frame,
   output lscl_pkg::scan_flags_type out_flags,
   output logic [FRAME_BITS-1:0]  out_frame,
   output logic [IDX_BITS-1:0]    out_hit_idx,
   output logic [IDX_BITS-1:0]    out_best_idx,
   output logic [STAMP_BITS-1:0]  out_best_stamp,
   output logic [FRAME_BITS-1:0]  out_best_frame,
   input  lscl_pkg::wr_flags_type wr_flags,
   input  logic [IDX_BITS-1:0]    wr_idx,
   input  logic [FRAME_BITS-1:0]  wr_frame,
   input  logic [STAMP_BITS-1:0]  wr_stamp
);
   import lscl_pkg::*;

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

   logic                  valid_ff;
   logic [FRAME_BITS-1:0] frame_ff;
   logic [STAMP_BITS-1:0] stamp_ff;

   scan_flags_type        flags_ff, flags_in;
   logic [FRAME_BITS-1:0] pkt_frame_ff;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [STAMP_BITS-1:0] best_stamp_ff, best_stamp_in;
   logic [FRAME_BITS-1:0] best_frame_ff, best_frame_in;

   logic match;
   logic take;
   logic wr_sel;

   assign match  = valid_ff && (frame_ff == in_frame);
   assign take   = !in_flags.best_set || (stamp_ff < in_best_stamp);
   assign wr_sel = wr_flags.en && (wr_idx == MY_IDX);

   always_comb begin
      flags_in.active     = in_flags.active;
      flags_in.hit        = in_flags.hit || match;
      flags_in.best_set   = 1'b1;
      flags_in.best_valid = take ? valid_ff : in_flags.best_valid;
      hit_idx_in          = in_flags.hit ? in_hit_idx : MY_IDX;
      best_idx_in         = take ? MY_IDX : in_best_idx;
      best_stamp_in       = take ? stamp_ff : in_best_stamp;
      best_frame_in       = take ? frame_ff : in_best_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         stamp_ff <= '0;
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
         if (wr_sel) begin
            stamp_ff <= wr_stamp;
            if (wr_flags.fill) begin
               valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pkt_frame_ff  <= in_frame;
      hit_idx_ff    <= hit_idx_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      best_frame_ff <= best_frame_in;
      if (wr_sel && wr_flags.fill) begin
         frame_ff <= wr_frame;
      end
   end

   assign out_flags      = flags_ff;
   assign out_frame      = pkt_frame_ff;
   assign out_hit_idx    = hit_idx_ff;
   assign out_best_idx   = best_idx_ff;
   assign out_best_stamp = best_stamp_ff;
   assign out_best_frame = best_frame_ff;

endmodule

// ----- sv/lru_slot_cache_lookup.sv -----
// Top level of the LRU slot cache lookup: request controller, slot chain
// and result register. Depends on lscl_pkg and lscl_slot.
//
// Usage: a fully associative directory of SLOTS slots with timestamp LRU.
// A request on req_ carries a frame number. One transfer on req_ gives
// exactly one transfer on rsp_: a hit and the slot that holds the frame, or
// a miss with the refilled slot and the frame it evicted, if any.
// The request walks the row of slots one slot per cycle, each slot folding
// its match and its stamp into the search record. The request passes the
// launch register, each slot register and the finish register before the
// result register is loaded; the next request is taken only once the
// controller is back in idle, so searches do not overlap.
// The result sits in an output register; a new request may be accepted
// while it waits. When the receiver stalls, a finished search waits in its
// last step and the directory is not updated until the previous result has
// been transferred.
// Reset makes every slot invalid with stamp zero, clears the access clock
// and drops any request in flight.
module lru_slot_cache_lookup #(
   parameter int SLOTS      = lscl_pkg::DEF_SLOTS,
   parameter int FRAME_BITS = lscl_pkg::DEF_FRAME_BITS,
   parameter int STAMP_BITS = lscl_pkg::DEF_STAMP_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lscl_pkg::REQ_FRAME_W-1:0]   req_frame_number,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [lscl_pkg::RSP_SLOT_W-1:0]    rsp_slot,
   output logic                               rsp_evicted_valid,
   output logic [lscl_pkg::RSP_FRAME_W-1:0]   rsp_evicted_frame
);
   import lscl_pkg::*;

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   ctrl_state_type state_ff, state_in;

   logic req_xfer;
   logic do_update;

   logic [STAMP_BITS-1:0] clock_ff;

   scan_flags_type        launch_flags_ff;
   logic [FRAME_BITS-1:0] launch_frame_ff;
   logic [FRAME_BITS-1:0] req_frame;
   logic [FRAME_BITS+REQ_FRAME_W-1:0] req_frame_ext;

   scan_flags_type        chain_flags      [SLOTS+1];
   logic [FRAME_BITS-1:0] chain_frame      [SLOTS+1];
   logic [IDX_BITS-1:0]   chain_hit_idx    [SLOTS+1];
   logic [IDX_BITS-1:0]   chain_best_idx   [SLOTS+1];
   logic [STAMP_BITS-1:0] chain_best_stamp [SLOTS+1];
   logic [FRAME_BITS-1:0] chain_best_frame [SLOTS+1];

   scan_flags_type        fin_flags_ff;
   logic [FRAME_BITS-1:0] fin_frame_ff;
   logic [IDX_BITS-1:0]   fin_hit_idx_ff;
   logic [IDX_BITS-1:0]   fin_best_idx_ff;
   logic [FRAME_BITS-1:0] fin_best_frame_ff;

   wr_flags_type          wr_flags;
   logic [IDX_BITS-1:0]   wr_idx;

   logic [IDX_BITS+RSP_SLOT_W-1:0]    slot_ext;
   logic [FRAME_BITS+RSP_FRAME_W-1:0] evict_ext;
   logic                              evict_valid;

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [RSP_SLOT_W-1:0]  rsp_slot_ff;
   logic                   rsp_evicted_valid_ff;
   logic [RSP_FRAME_W-1:0] rsp_evicted_frame_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain_flags[SLOTS].active) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      do_update = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   req_ready = 1'b0;
         ST_FINISH: do_update = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   assign req_xfer      = req_valid && req_ready;
   assign req_frame_ext = {{FRAME_BITS{1'b0}}, req_frame_number};
   assign req_frame     = req_frame_ext[FRAME_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         clock_ff        <= '0;
         launch_flags_ff <= '0;
      end else begin
         state_ff               <= state_in;
         launch_flags_ff.active <= req_xfer;
         if (req_xfer) begin
            clock_ff <= clock_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         launch_frame_ff <= req_frame;
      end
   end

   assign chain_flags[0]      = launch_flags_ff;
   assign chain_frame[0]      = launch_frame_ff;
   assign chain_hit_idx[0]    = '0;
   assign chain_best_idx[0]   = '0;
   assign chain_best_stamp[0] = '0;
   assign chain_best_frame[0] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      lscl_slot #(
         .SLOTS      (SLOTS),
         .FRAME_BITS (FRAME_BITS),
         .STAMP_BITS (STAMP_BITS),
         .IDX_BITS   (IDX_BITS),
         .CELL_IDX   (i)
      ) u_slot (
         .clock          (clock),
         .reset          (reset),
         .in_flags       (chain_flags[i]),
         .in_frame       (chain_frame[i]),
         .in_hit_idx     (chain_hit_idx[i]),
         .in_best_idx    (chain_best_idx[i]),
         .in_best_stamp  (chain_best_stamp[i]),
         .in_best_frame  (chain_best_frame[i]),
         .out_flags      (chain_flags[i+1]),
         .out_frame      (chain_frame[i+1]),
         .out_hit_idx    (chain_hit_idx[i+1]),
         .out_best_idx   (chain_best_idx[i+1]),
         .out_best_stamp (chain_best_stamp[i+1]),
         .out_best_frame (chain_best_frame[i+1]),
         .wr_flags       (wr_flags),
         .wr_idx         (wr_idx),
         .wr_frame       (fin_frame_ff),
         .wr_stamp       (clock_ff)
      );
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN && chain_flags[SLOTS].active) begin
         fin_flags_ff      <= chain_flags[SLOTS];
         fin_frame_ff      <= chain_frame[SLOTS];
         fin_hit_idx_ff    <= chain_hit_idx[SLOTS];
         fin_best_idx_ff   <= chain_best_idx[SLOTS];
         fin_best_frame_ff <= chain_best_frame[SLOTS];
      end
   end

   assign wr_idx        = fin_flags_ff.hit ? fin_hit_idx_ff : fin_best_idx_ff;
   assign wr_flags.en   = do_update;
   assign wr_flags.fill = !fin_flags_ff.hit;

   assign slot_ext    = {{RSP_SLOT_W{1'b0}}, wr_idx};
   assign evict_valid = !fin_flags_ff.hit && fin_flags_ff.best_valid;
   assign evict_ext   = evict_valid ? {{RSP_FRAME_W{1'b0}}, fin_best_frame_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_update) begin
         rsp_hit_ff           <= fin_flags_ff.hit;
         rsp_slot_ff          <= slot_ext[RSP_SLOT_W-1:0];
         rsp_evicted_valid_ff <= evict_valid;
         rsp_evicted_frame_ff <= evict_ext[RSP_FRAME_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_frame = rsp_evicted_frame_ff;

endmodule

// ----- sv/lscl_checker.sv -----
// Port-level checker for the LRU slot cache lookup top level.
// Watches only the top-level ports; bound to lru_slot_cache_lookup below.
// Depends on lscl_pkg.
module lscl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [lscl_pkg::REQ_FRAME_W-1:0] req_frame_number,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_hit,
   input logic [lscl_pkg::RSP_SLOT_W-1:0]  rsp_slot,
   input logic                             rsp_evicted_valid,
   input logic [lscl_pkg::RSP_FRAME_W-1:0] rsp_evicted_frame
);
   import lscl_pkg::*;

   logic [REQ_FRAME_W-1:0] unused_frame;
   assign unused_frame = req_frame_number;

   // A result cannot appear right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The directory searches one request at a time.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a search is running");

   // A hit never evicts anything.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted_valid)
      else $error("hit reports an eviction");

   // Without an eviction the evicted frame reads zero.
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted_valid) |-> (rsp_evicted_frame == '0))
      else $error("evicted frame nonzero without eviction");

   // A stalled result stays valid and keeps its slot and hit flag until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_slot) && $stable(rsp_hit)))
      else $error("stalled result changed");

endmodule

bind lru_slot_cache_lookup lscl_checker u_lscl_checker (.*);

// ----- verif/lscl_directory_check.sv -----
`timescale 1ns / 100ps
// Result checker for the LRU slot cache lookup: models the slot directory from the
// request transfers and compares every result transfer against the model in order.
// Depends on lscl_pkg.
module lscl_directory_check #(
   parameter int SLOTS = lscl_pkg::DEF_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [lscl_pkg::REQ_FRAME_W-1:0]  req_frame_number,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_hit,
   input  logic [lscl_pkg::RSP_SLOT_W-1:0]   rsp_slot,
   input  logic                              rsp_evicted_valid,
   input  logic [lscl_pkg::RSP_FRAME_W-1:0]  rsp_evicted_frame,
   output int                                fail_count,
   output int                                outstanding,
   output int                                results_checked,
   output int                                hit_count,
   output int                                evict_count
);

   localparam int FRAME_W = lscl_pkg::DEF_FRAME_BITS;
   localparam int STAMP_W = lscl_pkg::DEF_STAMP_BITS;

   typedef struct packed {
      logic                             hit;
      logic [lscl_pkg::RSP_SLOT_W-1:0]  slot;
      logic                             evicted_valid;
      logic [lscl_pkg::RSP_FRAME_W-1:0] evicted_frame;
   } lookup_result_type;

   logic               slot_held [SLOTS];
   logic [FRAME_W-1:0] slot_tag  [SLOTS];
   logic [STAMP_W-1:0] slot_age  [SLOTS];
   logic [STAMP_W-1:0] access_count;
   lookup_result_type  pending_results [$];

   function automatic lookup_result_type lookup_frame(
      input logic [lscl_pkg::REQ_FRAME_W-1:0] frame
   );
      lookup_result_type  res;
      logic [FRAME_W-1:0] tag;
      logic [STAMP_W-1:0] oldest;
      int                 victim;
      res = '0;
      tag = frame[FRAME_W-1:0];
      access_count = access_count + 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_held[i] && slot_tag[i] == tag) begin
            slot_age[i] = access_count;
            res.hit = 1'b1;
            res.slot = lscl_pkg::RSP_SLOT_W'(i);
            return res;
         end
      end
      victim = 0;
      oldest = slot_age[0];
      for (int i = 1; i < SLOTS; i++) begin
         if (slot_age[i] < oldest) begin
            oldest = slot_age[i];
            victim = i;
         end
      end
      res.slot = lscl_pkg::RSP_SLOT_W'(victim);
      res.evicted_valid = slot_held[victim];
      res.evicted_frame = slot_held[victim] ? lscl_pkg::RSP_FRAME_W'(slot_tag[victim]) : '0;
      slot_held[victim] = 1'b1;
      slot_tag[victim] = tag;
      slot_age[victim] = access_count;
      return res;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_held[i] = 1'b0;
            slot_tag[i] = '0;
            slot_age[i] = '0;
         end
         access_count = '0;
         pending_results.delete();
         fail_count = 0;
         results_checked = 0;
         hit_count = 0;
         evict_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            pending_results.push_back(lookup_frame(req_frame_number));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("Result transfer arrived with no request waiting for it.");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (want.hit) hit_count++;
               if (want.evicted_valid) evict_count++;
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  fail_count++;
               end
               if (rsp_evicted_valid !== want.evicted_valid) begin
                  $error("evicted_valid: expected %0d, got %0d",
                         want.evicted_valid, rsp_evicted_valid);
                  fail_count++;
               end
               if (rsp_evicted_frame !== want.evicted_frame) begin
                  $error("evicted_frame: expected 0x%04h, got 0x%04h",
                         want.evicted_frame, rsp_evicted_frame);
                  fail_count++;
               end
            end
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

// ----- verif/lru_slot_cache_lookup_test.sv -----
`timescale 1ns / 100ps
// Test top for the LRU slot cache lookup: clock, reset, frame requests and result
// back-pressure, with lscl_directory_check doing all prediction and comparison.
// Depends on lscl_pkg, lru_slot_cache_lookup and lscl_directory_check.
module lru_slot_cache_lookup_test;

   localparam int SLOTS        = lscl_pkg::DEF_SLOTS;
   localparam int RANDOM_ITEMS = 850;
   localparam int HOLD_AT      = 250;
   localparam int HOLD_CYCLES  = 300;
   localparam int CALM_FROM    = 400;
   localparam int CALM_TO      = 560;
   localparam int PAUSE_AT     = 650;
   localparam int DRAIN_CYCLES = 4 * (SLOTS + 3);
   localparam int CYCLE_LIMIT  = 200000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [lscl_pkg::REQ_FRAME_W-1:0] req_frame_number = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_hit;
   logic [lscl_pkg::RSP_SLOT_W-1:0]  rsp_slot;
   logic                             rsp_evicted_valid;
   logic [lscl_pkg::RSP_FRAME_W-1:0] rsp_evicted_frame;

   int fail_count;
   int outstanding;
   int results_checked;
   int hit_count;
   int evict_count;
   int requests_sent = 0;
   int cycle_count = 0;
   bit calm = 1'b0;
   bit hold_off_req = 1'b0;

   logic [15:0] corner_frames [18] = '{
      16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
      16'h5555, 16'hAAAA, 16'h1234, 16'hFFFF, 16'h1234, 16'h00FF,
      16'h0000, 16'h0001, 16'hFF00, 16'h0000, 16'hFFFF, 16'h8000
   };

   lru_slot_cache_lookup dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_number  (req_frame_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_frame (rsp_evicted_frame)
   );

   lscl_directory_check #(.SLOTS(SLOTS)) directory_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_number  (req_frame_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_frame (rsp_evicted_frame),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .results_checked   (results_checked),
      .hit_count         (hit_count),
      .evict_count       (evict_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("lru_slot_cache_lookup_test: errors");
         $finish;
      end
   end

   task automatic offer_frame(input logic [15:0] frame);
      int gap;
      req_valid <= 1'b1;
      req_frame_number <= frame;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      if (requests_sent == HOLD_AT) hold_off_req = 1'b1;
      if (requests_sent == PAUSE_AT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (outstanding != 0) @(posedge clock);
      end else if (!calm && $urandom_range(99) < 30) begin
         gap = $urandom_range(8, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : result_drain
      int held;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   initial begin : stimulus
      logic [15:0] pool [16];
      int          pool_size;
      int          burst;
      int          mode;
      int          bit_pos;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (corner_frames[k]) offer_frame(corner_frames[k]);
      while (requests_sent < RANDOM_ITEMS + $size(corner_frames)) begin
         calm = (requests_sent >= CALM_FROM && requests_sent < CALM_TO);
         mode = $urandom_range(9);
         if (mode < 6) begin
            case ($urandom_range(6))
               0: pool_size = 2;
               1: pool_size = 4;
               2: pool_size = 7;
               3: pool_size = 8;
               4: pool_size = 9;
               5: pool_size = 12;
               default: pool_size = 16;
            endcase
            for (int k = 0; k < pool_size; k++) begin
               if (k % 2 == 1 && $urandom_range(1) == 1) begin
                  pool[k] = pool[k - 1] ^ (16'h1 << $urandom_range(15));
               end else begin
                  pool[k] = 16'($urandom_range(16'hFFFF));
               end
            end
            burst = $urandom_range(40, 10);
            for (int k = 0; k < burst; k++) begin
               if (mode < 2) offer_frame(pool[k % pool_size]);
               else offer_frame(pool[$urandom_range(pool_size - 1)]);
            end
         end else if (mode < 9) begin
            burst = $urandom_range(15, 5);
            for (int k = 0; k < burst; k++) offer_frame(16'($urandom_range(16'hFFFF)));
         end else begin
            burst = $urandom_range(12, 4);
            for (int k = 0; k < burst; k++) begin
               bit_pos = $urandom_range(15);
               case ($urandom_range(3))
                  0: offer_frame(16'h0000);
                  1: offer_frame(16'hFFFF);
                  2: offer_frame(16'h1 << bit_pos);
                  default: offer_frame(~(16'h1 << bit_pos));
               endcase
            end
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d of %0d frame requests: %0d hits, %0d misses, %0d evictions.",
               results_checked, requests_sent, hit_count, results_checked - hit_count,
               evict_count);
      $display("Covered corner frames, working sets of 2 to 16 frames, random noise,");
      $display("a long result stall and a full drain pause.");
      if (fail_count == 0) begin
         $display("lru_slot_cache_lookup_test: clean");
      end else begin
         $display("lru_slot_cache_lookup_test: errors");
      end
      $finish;
   end

endmodule
